### hdl/hcbd_pkg.sv
// Shared types, constants and helpers for the chunked HTTP body decoder.
// No dependencies; used by every module of the decoder.
package hcbd_pkg;

	localparam int DefaultLengthBits  = 32;
	localparam int DefaultMaxHexDigits = 8;

	localparam logic [7:0] CharCr = 8'h0D;
	localparam logic [7:0] CharLf = 8'h0A;

	localparam logic [1:0] StatusBusy = 2'd0;
	localparam logic [1:0] StatusOk   = 2'd1;
	localparam logic [1:0] StatusBad  = 2'd2;

	localparam logic [3:0] DigitCountMax = 4'd15;

	typedef enum logic [5:0] {
		PH_SIZE  = 6'b000001,
		PH_DATA  = 6'b000010,
		PH_CR    = 6'b000100,
		PH_LF    = 6'b001000,
		PH_DONE  = 6'b010000,
		PH_ERROR = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [3:0] digits;
		logic       invalid;
		logic       cr_pending;
	} line_flags_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [1:0]  decode_status;
		logic [31:0] decoded_length;
	} result_t;

	// Returns {is_hex, value}.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = 5'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				r = {1'b1, 4'(c - 8'h30)};
			end else if (c >= 8'h41 && c <= 8'h46) begin
				r = {1'b1, 4'(c - 8'h37)};
			end else if (c >= 8'h61 && c <= 8'h66) begin
				r = {1'b1, 4'(c - 8'h57)};
			end
			return r;
		end
	endfunction

endpackage

### hdl/http_chunked_body_decoder_unit.sv
// Top level of the chunked HTTP body decoder: input register, decoder core
// and result register. Depends on hcbd_pkg and hcbd_core.
//
// Body bytes arrive on the s_ stream, one byte per transfer, with s_tlast on
// the final byte of each body. Every input transfer yields exactly one result
// transfer on the m_ stream, carrying the payload byte (when the byte belongs
// to a chunk), the decode status and the running decoded length.
// A byte is held in the input register and its result is computed into the
// result register once that register is empty or its result is being taken,
// and is then presented on m_tvalid. One byte per cycle is sustained while the
// receiver keeps m_tready high; the throughput is set by the single per-byte
// state update in the core.
// When the receiver stalls, the result register holds its value and the input
// register still takes one more byte; further input waits on s_tready until
// the result is taken. Reset clears both registers' valid flags and returns
// the decoder to the start of a size line with a zero length. A transfer with
// s_tlast also returns the decoder to that state after its result is formed.
module http_chunked_body_decoder_unit #(
	parameter int LENGTH_BITS    = hcbd_pkg::DefaultLengthBits,
	parameter int MAX_HEX_DIGITS = hcbd_pkg::DefaultMaxHexDigits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] body_byte
	input  logic        s_tlast,   // body_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [0] payload_valid, [8:1] payload_byte,
	                               // [10:9] decode_status, [42:11] decoded_length
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              valid_s2;
	hcbd_pkg::result_t result_s2;
	hcbd_pkg::result_t result;
	logic              advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	hcbd_core #(
		.LENGTH_BITS   (LENGTH_BITS),
		.MAX_HEX_DIGITS(MAX_HEX_DIGITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.body_byte(byte_s1),
		.body_last(last_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, result_s2.decoded_length, result_s2.decode_status,
		result_s2.payload_byte, result_s2.payload_valid};

endmodule

### hdl/hcbd_line.sv
// Size line parser: folds one byte into the hex size being collected.
// Depends on hcbd_pkg.
module hcbd_line #(
	parameter int LENGTH_BITS    = hcbd_pkg::DefaultLengthBits,
	parameter int MAX_HEX_DIGITS = hcbd_pkg::DefaultMaxHexDigits
) (
	input  logic [7:0]             body_byte,
	input  logic [LENGTH_BITS-1:0] acc,
	input  hcbd_pkg::line_flags_t  flags,
	output logic [LENGTH_BITS-1:0] acc_next,
	output hcbd_pkg::line_flags_t  flags_next,
	output logic                   line_end
);

	logic [4:0] hex;
	logic       too_big;

	assign hex     = hcbd_pkg::hex_decode(body_byte);
	assign too_big = ({1'b0, flags.digits} >= 5'(MAX_HEX_DIGITS))
		|| (acc[LENGTH_BITS-1 -: 4] != 4'd0);

	always_comb begin
		acc_next   = acc;
		flags_next = flags;
		line_end   = 1'b0;
		if (flags.cr_pending && body_byte == hcbd_pkg::CharLf) begin
			line_end = 1'b1;
		end else begin
			if (flags.cr_pending) begin
				flags_next.invalid    = 1'b1;
				flags_next.cr_pending = 1'b0;
			end
			if (body_byte == hcbd_pkg::CharCr) begin
				flags_next.cr_pending = 1'b1;
			end else if (!hex[4]) begin
				flags_next.invalid = 1'b1;
			end else if (!flags_next.invalid && !(acc == '0 && hex[3:0] == 4'd0)) begin
				if (too_big) begin
					flags_next.invalid = 1'b1;
				end else begin
					acc_next = {acc[LENGTH_BITS-5:0], hex[3:0]};
					if (flags.digits != hcbd_pkg::DigitCountMax) begin
						flags_next.digits = flags.digits + 4'd1;
					end
				end
			end
		end
	end

endmodule

### hdl/hcbd_core.sv
// Decoder state and phase machine; produces one result per stepped byte.
// Depends on hcbd_pkg and hcbd_line.
module hcbd_core #(
	parameter int LENGTH_BITS    = hcbd_pkg::DefaultLengthBits,
	parameter int MAX_HEX_DIGITS = hcbd_pkg::DefaultMaxHexDigits
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        body_byte,
	input  logic              body_last,
	output hcbd_pkg::result_t result
);

	hcbd_pkg::phase_t      phase_q, phase_d;
	logic [LENGTH_BITS-1:0] remaining_q, remaining_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d, acc_line;
	hcbd_pkg::line_flags_t flags_q, flags_d, flags_line;
	logic [31:0]           total_q, total_d;
	logic                  line_end;
	logic [LENGTH_BITS-1:0] remaining_dec;

	hcbd_line #(
		.LENGTH_BITS   (LENGTH_BITS),
		.MAX_HEX_DIGITS(MAX_HEX_DIGITS)
	) u_line (
		.body_byte (body_byte),
		.acc       (acc_q),
		.flags     (flags_q),
		.acc_next  (acc_line),
		.flags_next(flags_line),
		.line_end  (line_end)
	);

	assign remaining_dec = remaining_q - LENGTH_BITS'(1);

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		acc_d       = acc_q;
		flags_d     = flags_q;
		total_d     = total_q;
		result      = '0;
		case (phase_q)
			hcbd_pkg::PH_SIZE: begin
				if (line_end) begin
					if (flags_q.invalid) begin
						phase_d = hcbd_pkg::PH_ERROR;
					end else if (acc_q == '0) begin
						phase_d = hcbd_pkg::PH_DONE;
					end else begin
						remaining_d = acc_q;
						phase_d     = hcbd_pkg::PH_DATA;
					end
					acc_d   = '0;
					flags_d = '0;
				end else begin
					acc_d   = acc_line;
					flags_d = flags_line;
				end
			end
			hcbd_pkg::PH_DATA: begin
				result.payload_valid = 1'b1;
				result.payload_byte  = body_byte;
				total_d              = total_q + 32'd1;
				remaining_d          = remaining_dec;
				if (remaining_dec == '0) begin
					phase_d = hcbd_pkg::PH_CR;
				end
			end
			hcbd_pkg::PH_CR: begin
				phase_d = (body_byte == hcbd_pkg::CharCr) ? hcbd_pkg::PH_LF
					: hcbd_pkg::PH_ERROR;
			end
			hcbd_pkg::PH_LF: begin
				phase_d = (body_byte == hcbd_pkg::CharLf) ? hcbd_pkg::PH_SIZE
					: hcbd_pkg::PH_ERROR;
			end
			hcbd_pkg::PH_DONE, hcbd_pkg::PH_ERROR: begin
				phase_d = phase_q;
			end
			default: begin
				phase_d = hcbd_pkg::PH_ERROR;
			end
		endcase

		if (phase_d == hcbd_pkg::PH_DONE) begin
			result.decode_status = hcbd_pkg::StatusOk;
		end else if (phase_d == hcbd_pkg::PH_ERROR) begin
			result.decode_status = hcbd_pkg::StatusBad;
		end else if (body_last) begin
			result.decode_status = (phase_d == hcbd_pkg::PH_SIZE) ? hcbd_pkg::StatusOk
				: hcbd_pkg::StatusBad;
		end else begin
			result.decode_status = hcbd_pkg::StatusBusy;
		end
		result.decoded_length = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hcbd_pkg::PH_SIZE;
			remaining_q <= '0;
			acc_q       <= '0;
			flags_q     <= '0;
			total_q     <= '0;
		end else if (step) begin
			if (body_last) begin
				phase_q     <= hcbd_pkg::PH_SIZE;
				remaining_q <= '0;
				acc_q       <= '0;
				flags_q     <= '0;
				total_q     <= '0;
			end else begin
				phase_q     <= phase_d;
				remaining_q <= remaining_d;
				acc_q       <= acc_d;
				flags_q     <= flags_d;
				total_q     <= total_d;
			end
		end
	end

endmodule

### tb/testbench.sv
// Self-checking testbench for http_chunked_body_decoder_unit, with a built-in decoder model.
// Uses the types and constants of hcbd_pkg. Bodies are directed, then random and mostly
// well formed. Both streams stall at random, and one test holds the receiver off for a long time.
module testbench;

	localparam int          MaxDigits  = hcbd_pkg::DefaultMaxHexDigits;
	localparam logic [31:0] ShiftLimit = 32'hFFFF_FFFF >> 4;
	localparam int          ItemTarget = 1350;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	hcbd_pkg::phase_t dec_phase;
	logic [31:0] chunk_left;
	logic [31:0] size_acc;
	logic [3:0]  digit_cnt;
	logic        line_bad;
	logic        cr_seen;
	logic [31:0] body_len;

	hcbd_pkg::result_t pending_results[$];
	logic [7:0]  body_bytes[$];
	int          error_count    = 0;
	int          items_sent     = 0;
	int          rx_hold_cycles = 0;
	bit          tx_steady      = 1'b0;
	bit          rx_steady      = 1'b0;

	http_chunked_body_decoder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic void clear_line();
		size_acc  = 32'd0;
		digit_cnt = 4'd0;
		line_bad  = 1'b0;
		cr_seen   = 1'b0;
	endfunction

	function automatic void clear_decoder();
		dec_phase  = hcbd_pkg::PH_SIZE;
		chunk_left = 32'd0;
		body_len   = 32'd0;
		clear_line();
	endfunction

	initial clear_decoder();

	// Advances the decoder model by one body byte and returns the result it produces.
	function automatic hcbd_pkg::result_t decode_byte(input logic [7:0] c, input logic last);
		hcbd_pkg::result_t r;
		logic [4:0] hv;
		r = '0;
		hv = 5'd0;
		if (c >= "0" && c <= "9") begin
			hv = {1'b1, 4'(c - 8'h30)};
		end else if (c >= "A" && c <= "F") begin
			hv = {1'b1, 4'(c - 8'h37)};
		end else if (c >= "a" && c <= "f") begin
			hv = {1'b1, 4'(c - 8'h57)};
		end
		case (dec_phase)
			hcbd_pkg::PH_SIZE: begin
				if (cr_seen && c == hcbd_pkg::CharLf) begin
					if (line_bad) begin
						dec_phase = hcbd_pkg::PH_ERROR;
					end else if (size_acc == 32'd0) begin
						dec_phase = hcbd_pkg::PH_DONE;
					end else begin
						chunk_left = size_acc;
						dec_phase  = hcbd_pkg::PH_DATA;
					end
					clear_line();
				end else begin
					if (cr_seen) begin
						line_bad = 1'b1;
						cr_seen  = 1'b0;
					end
					if (c == hcbd_pkg::CharCr) begin
						cr_seen = 1'b1;
					end else if (!hv[4]) begin
						line_bad = 1'b1;
					end else if (!line_bad && !(size_acc == 32'd0 && hv[3:0] == 4'd0)) begin
						if (digit_cnt >= MaxDigits || size_acc > ShiftLimit) begin
							line_bad = 1'b1;
						end else begin
							size_acc = {size_acc[27:0], hv[3:0]};
							if (digit_cnt < hcbd_pkg::DigitCountMax)
								digit_cnt++;
						end
					end
				end
			end
			hcbd_pkg::PH_DATA: begin
				r.payload_valid = 1'b1;
				r.payload_byte  = c;
				body_len++;
				chunk_left--;
				if (chunk_left == 32'd0)
					dec_phase = hcbd_pkg::PH_CR;
			end
			hcbd_pkg::PH_CR: dec_phase = (c == hcbd_pkg::CharCr) ? hcbd_pkg::PH_LF
				: hcbd_pkg::PH_ERROR;
			hcbd_pkg::PH_LF: dec_phase = (c == hcbd_pkg::CharLf) ? hcbd_pkg::PH_SIZE
				: hcbd_pkg::PH_ERROR;
			hcbd_pkg::PH_DONE, hcbd_pkg::PH_ERROR: ;
			default: dec_phase = hcbd_pkg::PH_ERROR;
		endcase
		if (dec_phase == hcbd_pkg::PH_DONE)
			r.decode_status = hcbd_pkg::StatusOk;
		else if (dec_phase == hcbd_pkg::PH_ERROR)
			r.decode_status = hcbd_pkg::StatusBad;
		else if (last)
			r.decode_status = (dec_phase == hcbd_pkg::PH_SIZE) ? hcbd_pkg::StatusOk
				: hcbd_pkg::StatusBad;
		else
			r.decode_status = hcbd_pkg::StatusBusy;
		r.decoded_length = body_len;
		if (last)
			clear_decoder();
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!tx_steady && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(decode_byte(b, last));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_body();
		foreach (body_bytes[i])
			send_byte(body_bytes[i], i == body_bytes.size() - 1);
		body_bytes.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			body_bytes.push_back(s[i]);
	endtask

	task automatic add_crlf();
		body_bytes.push_back(hcbd_pkg::CharCr);
		body_bytes.push_back(hcbd_pkg::CharLf);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] base;
		if (d < 4'd10)
			base = "0";
		else
			base = ($urandom_range(1) ? "A" : "a") - 8'd10;
		return base + {4'd0, d};
	endfunction

	task automatic add_size(input logic [31:0] sz, input int zeros);
		bit started;
		started = 1'b0;
		repeat (zeros) body_bytes.push_back("0");
		for (int i = 7; i >= 0; i--) begin
			if (sz[i*4 +: 4] != 4'd0 || started || i == 0) begin
				started = 1'b1;
				body_bytes.push_back(hex_char(sz[i*4 +: 4]));
			end
		end
	endtask

	// Mostly well-formed bodies with random content; a few are noise, oversized,
	// truncated or corrupted.
	task automatic build_random_body();
		int          r;
		int          n_chunks;
		int          pos;
		logic [31:0] sz;
		bit          cut;
		cut = 1'b0;
		if ($urandom_range(99) < 6) begin
			repeat ($urandom_range(1, 12)) body_bytes.push_back(8'($urandom));
		end else begin
			n_chunks = $urandom_range(0, 3);
			for (int k = 0; k < n_chunks && !cut; k++) begin
				r = $urandom_range(99);
				if (r < 4) begin
					body_bytes.push_back(hex_char(4'($urandom_range(1, 15))));
					add_size($urandom | 32'h1000_0000, 0);
					add_crlf();
					cut = 1'b1;
				end else if (r < 8) begin
					sz = (r == 4) ? 32'hFFFF_FFFF : ($urandom | 32'h0100_0000);
					add_size(sz, $urandom_range(2));
					add_crlf();
					repeat ($urandom_range(0, 6)) body_bytes.push_back(8'($urandom));
					cut = 1'b1;
				end else begin
					sz = (r < 15) ? $urandom_range(13, 200) : $urandom_range(1, 12);
					add_size(sz, ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0);
					add_crlf();
					repeat (sz) body_bytes.push_back(8'($urandom));
					add_crlf();
				end
			end
			if (!cut) begin
				r = $urandom_range(9);
				if (r == 1) begin
					add_size($urandom_range(1, 255), 0);
				end else if (r == 2) begin
					add_crlf();
				end else if (r > 2) begin
					add_size(32'd0, $urandom_range(2));
					add_crlf();
					repeat ($urandom_range(0, 3)) body_bytes.push_back(8'($urandom));
				end
			end
		end
		if (body_bytes.size() == 0)
			body_bytes.push_back("0");
		if ($urandom_range(99) < 15) begin
			pos = $urandom_range(body_bytes.size() - 1);
			case ($urandom_range(2))
				0: body_bytes[pos] = 8'($urandom);
				1: body_bytes[pos] = hcbd_pkg::CharCr;
				default: while (body_bytes.size() > pos + 1) void'(body_bytes.pop_back());
			endcase
		end
	endtask

	// Payload extremes, a terminating zero line and a byte ignored after it.
	task automatic test_basic_chunk();
		add_text("2");
		add_crlf();
		body_bytes.push_back(8'h00);
		body_bytes.push_back(8'hFF);
		add_crlf();
		add_text("0");
		add_crlf();
		add_text("x");
		send_body();
	endtask

	// A lone carriage return and a non-hex character; the error shows only at the line end.
	task automatic test_bad_size_line();
		add_text("1");
		body_bytes.push_back(hcbd_pkg::CharCr);
		add_text("g");
		add_crlf();
		add_text("A");
		send_body();
	endtask

	// Nine significant digits exceed the size limit.
	task automatic test_oversized_size();
		add_text("123456789");
		add_crlf();
		send_body();
	endtask

	// A body ending inside payload is malformed; one ending inside a size line is not.
	task automatic test_body_end_cases();
		add_text("1");
		add_crlf();
		add_text("Z");
		send_body();
		add_text("G");
		send_body();
	endtask

	task automatic test_full_rate();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		repeat (8) begin
			build_random_body();
			send_body();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	task automatic test_backpressure();
		tx_steady      = 1'b1;
		rx_hold_cycles = 120;
		add_text("1e");
		add_crlf();
		repeat (30) body_bytes.push_back(8'($urandom));
		add_crlf();
		add_text("0");
		add_crlf();
		send_body();
		tx_steady = 1'b0;
	endtask

	task automatic test_random_bodies();
		while (items_sent < ItemTarget) begin
			build_random_body();
			send_body();
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				m_tready <= 1'b0;
				rx_hold_cycles--;
			end else begin
				m_tready <= rx_steady || ($urandom_range(99) >= 38);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		hcbd_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("payload_valid", 32'(want.payload_valid), 32'(m_tdata[0]));
				check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[8:1]));
				check_field("decode_status", 32'(want.decode_status), 32'(m_tdata[10:9]));
				check_field("decoded_length", want.decoded_length, m_tdata[42:11]);
			end
		end
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basic_chunk();
		test_bad_size_line();
		test_oversized_size();
		test_body_end_cases();
		test_full_rate();
		test_backpressure();
		test_random_bodies();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
